// ===== hdl/cfl_time_step_reduction_assert.svh =====
// ----------------------------------------------------------------------------
// CFL time step reduction assertion macros
// Shared property forms for the block's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef CFL_TIME_STEP_REDUCTION_ASSERT_SVH
`define CFL_TIME_STEP_REDUCTION_ASSERT_SVH

// same-cycle implication
`define CFL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cfl check failed");

// next-cycle implication
`define CFL_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cfl check failed");

`endif

// ===== hdl/cfl_pkg.sv =====
// ----------------------------------------------------------------------------
// CFL time step reduction package
// Shared constants, register indexes, item classes and word types.
// ----------------------------------------------------------------------------
`default_nettype none

package cfl_pkg;

  localparam int DIMENSIONS = 3;
  localparam int DIM_W = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  localparam logic [2:0] REG_FIXED_MODE = 3'd0;
  localparam logic [2:0] REG_FIXED_STEP = 3'd1;
  localparam logic [2:0] REG_CFL_FACTOR = 3'd2;
  localparam logic [2:0] REG_STEP_MAX   = 3'd3;
  localparam logic [2:0] REG_STEP_MIN   = 3'd4;
  localparam logic [2:0] REG_CELL_X     = 3'd5;
  localparam logic [2:0] REG_CELL_Y     = 3'd6;
  localparam logic [2:0] REG_CELL_Z     = 3'd7;

  localparam logic [1:0] KIND_SOLID = 2'd0;
  localparam logic [1:0] KIND_FLUID = 2'd1;

  localparam logic [1:0] CLS_SKIP  = 2'd0;
  localparam logic [1:0] CLS_SOLID = 2'd1;
  localparam logic [1:0] CLS_FLUID = 2'd2;
  localparam logic [1:0] CLS_NONE  = 2'd3;

  typedef struct packed {
    logic             fixed_mode;
    logic [63:0]      fixed_step;
    logic [48:0]      cfl_factor;
    logic [63:0]      step_max;
    logic [63:0]      step_min;
    logic [2:0][47:0] dx;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       cls;
    logic [47:0]      e;
    logic [14:0]      nu;
    logic [47:0]      k;
    logic [39:0]      rho;
    logic [2:0][47:0] vel;
    logic             last;
  } word_t;

endpackage

`default_nettype wire

// ===== hdl/cfl_front.sv =====
// ----------------------------------------------------------------------------
// CFL front end
// Holds the configuration registers, accepts particles and tags each with
// its work class before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl_front import cfl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        is_material,
  input  wire logic [1:0]  model_kind,
  input  wire logic [47:0] youngs_modulus,
  input  wire logic [14:0] poisson_ratio,
  input  wire logic [47:0] fluid_modulus,
  input  wire logic [39:0] mass_density,
  input  wire logic signed [47:0] vel_x,
  input  wire logic signed [47:0] vel_y,
  input  wire logic signed [47:0] vel_z,
  input  wire logic        last_particle,
  input  wire logic        q_full,
  output logic             q_push,
  output word_t            q_wdata,
  output cfg_t             cfg
);

  assign cfg_ready  = 1'b1;
  assign item_stall = q_full;
  assign q_push     = item_valid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_mode <= 1'b0;
      cfg.fixed_step <= '0;
      cfg.cfl_factor <= 49'h0800000000000;
      cfg.step_max   <= '1;
      cfg.step_min   <= '0;
      cfg.dx[0]      <= 48'h000001000000;
      cfg.dx[1]      <= 48'h000001000000;
      cfg.dx[2]      <= 48'h000001000000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FIXED_MODE: cfg.fixed_mode <= cfg_data[0];
        REG_FIXED_STEP: cfg.fixed_step <= cfg_data;
        REG_CFL_FACTOR: cfg.cfl_factor <= cfg_data[48:0];
        REG_STEP_MAX:   cfg.step_max   <= cfg_data;
        REG_STEP_MIN:   cfg.step_min   <= cfg_data;
        REG_CELL_X:     cfg.dx[0]      <= cfg_data[47:0];
        REG_CELL_Y:     cfg.dx[1]      <= cfg_data[47:0];
        REG_CELL_Z:     cfg.dx[2]      <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    q_wdata.e    = youngs_modulus;
    q_wdata.nu   = poisson_ratio;
    q_wdata.k    = fluid_modulus;
    q_wdata.rho  = mass_density;
    q_wdata.vel[0] = vel_x;
    q_wdata.vel[1] = vel_y;
    q_wdata.vel[2] = vel_z;
    q_wdata.last = last_particle;
    if (!is_material) begin
      q_wdata.cls = CLS_SKIP;
    end else begin
      case (model_kind)
        KIND_SOLID: q_wdata.cls = CLS_SOLID;
        KIND_FLUID: q_wdata.cls = CLS_FLUID;
        default:    q_wdata.cls = CLS_NONE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfl_queue.sv =====
// ----------------------------------------------------------------------------
// CFL particle queue
// Two-word queue between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cfl_queue import cfl_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire word_t wdata,
  input  wire logic  pop,
  output word_t      rdata,
  output logic       full,
  output logic       empty
);

  word_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/cfl_back.sv =====
// ----------------------------------------------------------------------------
// CFL back end
// Sequencer over a shared 64x16 multiplier, a bit-serial divider and a
// digit-serial square root; keeps the running minimum and emits the step.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cfl_time_step_reduction_assert.svh"

module cfl_back import cfl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire word_t       q_rdata,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      time_step
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DIV  = 4'd2;
  localparam logic [3:0] S_SQRT = 4'd3;
  localparam logic [3:0] S_MDIV = 4'd4;
  localparam logic [3:0] S_SPD  = 4'd5;
  localparam logic [3:0] S_WSQ  = 4'd6;
  localparam logic [3:0] S_VST  = 4'd7;
  localparam logic [3:0] S_VLD  = 4'd8;
  localparam logic [3:0] S_VNX  = 4'd9;
  localparam logic [3:0] S_VMAG = 4'd10;
  localparam logic [3:0] S_STEP = 4'd11;
  localparam logic [3:0] S_UPD  = 4'd12;
  localparam logic [3:0] S_FIN  = 4'd13;
  localparam logic [3:0] S_EMIT = 4'd14;

  logic [3:0]       state;
  logic [3:0]       ret;
  word_t            cur;
  logic [63:0]      run_min;
  logic [63:0]      step;
  logic [63:0]      wave;
  logic [63:0]      t;
  logic [DIM_W-1:0] dim;

  logic [63:0]  mul_a;
  logic [63:0]  mul_b;
  logic [127:0] acc;
  logic [1:0]   mul_cnt;
  logic [79:0]  partial;

  logic [127:0] num;
  logic [63:0]  den;
  logic [64:0]  drem;
  logic [127:0] quo;
  logic [6:0]   dcnt;
  logic [64:0]  dtry;
  logic [127:0] div_q;
  logic [63:0]  div_sat;

  logic [127:0] rad;
  logic [65:0]  srem;
  logic [63:0]  root;
  logic [5:0]   scnt;
  logic [65:0]  strial;
  logic [65:0]  stry;

  logic [47:0]  dxmin;
  logic [47:0]  vsel;
  logic [47:0]  vmag;
  logic [33:0]  den_nu;
  logic [64:0]  sum65;
  logic [63:0]  sum;
  logic [63:0]  new_min;
  logic [63:0]  scaled;
  logic [63:0]  clamped;
  logic         emit_fire;

  assign q_pop     = (state == S_IDLE) && !q_empty;
  assign emit_fire = (state == S_EMIT) && (!result_valid || !result_stall);

  always_comb begin
    dxmin = cfg.dx[0];
    for (int d = 1; d < DIMENSIONS; d++) begin
      if (cfg.dx[d] < dxmin) begin
        dxmin = cfg.dx[d];
      end
    end
  end

  assign vsel    = cur.vel[dim];
  assign vmag    = vsel[47] ? (48'd0 - vsel) : vsel;
  assign den_nu  = (17'h10000 + {2'b00, cur.nu}) * (17'h10000 - {1'b0, cur.nu, 1'b0});
  assign partial = mul_a * mul_b[{mul_cnt, 4'b0000} +: 16];
  assign dtry    = {drem[63:0], num[127]};
  assign div_q   = (den == 64'd0) ? '1 : quo;
  assign div_sat = (|div_q[127:64]) ? '1 : div_q[63:0];
  assign strial  = {root, 2'b01};
  assign stry    = {srem[63:0], rad[127:126]};
  assign sum65   = {1'b0, wave} + {1'b0, root};
  assign sum     = sum65[64] ? '1 : sum65[63:0];
  assign new_min = (step < run_min) ? step : run_min;
  assign scaled  = (|acc[127:112]) ? '1 : acc[111:48];

  always_comb begin
    clamped = scaled;
    if (clamped > cfg.step_max) begin
      clamped = cfg.step_max;
    end
    if (clamped < cfg.step_min) begin
      clamped = cfg.step_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      run_min <= '1;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_rdata;
            case (q_rdata.cls)
              CLS_SKIP: begin
                step  <= '1;
                state <= S_UPD;
              end
              CLS_SOLID: begin
                mul_a   <= {16'd0, q_rdata.e};
                mul_b   <= 64'h10000 - {49'd0, q_rdata.nu};
                acc     <= '0;
                mul_cnt <= 2'd0;
                ret     <= S_MDIV;
                state   <= S_MUL;
              end
              CLS_FLUID: begin
                num   <= {8'd0, 16'd0, q_rdata.k, 56'd0};
                den   <= {24'd0, q_rdata.rho};
                drem  <= '0;
                quo   <= '0;
                dcnt  <= '0;
                ret   <= S_WSQ;
                state <= S_DIV;
              end
              default: begin
                root  <= '0;
                state <= S_VST;
              end
            endcase
          end
        end
        S_MUL: begin
          acc     <= acc + ({48'd0, partial} << {mul_cnt, 4'b0000});
          mul_cnt <= mul_cnt + 2'd1;
          if (mul_cnt == 2'd3) begin
            state <= ret;
          end
        end
        S_DIV: begin
          num  <= {num[126:0], 1'b0};
          dcnt <= dcnt + 7'd1;
          if (dtry >= {1'b0, den}) begin
            drem <= dtry - {1'b0, den};
            quo  <= {quo[126:0], 1'b1};
          end else begin
            drem <= dtry;
            quo  <= {quo[126:0], 1'b0};
          end
          if (dcnt == 7'h7f) begin
            state <= ret;
          end
        end
        S_SQRT: begin
          rad  <= {rad[125:0], 2'b00};
          scnt <= scnt + 6'd1;
          if (stry >= strial) begin
            srem <= stry - strial;
            root <= {root[62:0], 1'b1};
          end else begin
            srem <= stry;
            root <= {root[62:0], 1'b0};
          end
          if (scnt == 6'h3f) begin
            state <= ret;
          end
        end
        S_MDIV: begin
          num   <= {acc[111:0], 16'd0};
          den   <= {30'd0, den_nu};
          drem  <= '0;
          quo   <= '0;
          dcnt  <= '0;
          ret   <= S_SPD;
          state <= S_DIV;
        end
        S_SPD: begin
          num   <= {8'd0, div_sat, 56'd0};
          den   <= {24'd0, cur.rho};
          drem  <= '0;
          quo   <= '0;
          dcnt  <= '0;
          ret   <= S_WSQ;
          state <= S_DIV;
        end
        S_WSQ: begin
          rad   <= div_q;
          srem  <= '0;
          root  <= '0;
          scnt  <= '0;
          ret   <= S_VST;
          state <= S_SQRT;
        end
        S_VST: begin
          wave  <= root;
          acc   <= '0;
          dim   <= '0;
          state <= S_VLD;
        end
        S_VLD: begin
          mul_a   <= {16'd0, vmag};
          mul_b   <= {16'd0, vmag};
          mul_cnt <= 2'd0;
          ret     <= S_VNX;
          state   <= S_MUL;
        end
        S_VNX: begin
          if (dim == DIM_W'(DIMENSIONS - 1)) begin
            rad   <= acc;
            srem  <= '0;
            root  <= '0;
            scnt  <= '0;
            ret   <= S_VMAG;
            state <= S_SQRT;
          end else begin
            dim   <= dim + DIM_W'(1);
            state <= S_VLD;
          end
        end
        S_VMAG: begin
          if (sum == 64'd0) begin
            step  <= '1;
            state <= S_UPD;
          end else begin
            num   <= {32'd0, dxmin, 48'd0};
            den   <= sum;
            drem  <= '0;
            quo   <= '0;
            dcnt  <= '0;
            ret   <= S_STEP;
            state <= S_DIV;
          end
        end
        S_STEP: begin
          step  <= div_sat;
          state <= S_UPD;
        end
        S_UPD: begin
          run_min <= new_min;
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (cfg.fixed_mode) begin
            t     <= cfg.fixed_step;
            state <= S_EMIT;
          end else begin
            mul_a   <= {15'd0, cfg.cfl_factor};
            mul_b   <= new_min;
            acc     <= '0;
            mul_cnt <= 2'd0;
            ret     <= S_FIN;
            state   <= S_MUL;
          end
        end
        S_FIN: begin
          t     <= clamped;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            run_min <= '1;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit_fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      time_step <= t;
    end
  end

  `CFL_ASSERT_IMP(a_pop_idle, clk, rst, q_pop, state == S_IDLE)
  `CFL_ASSERT_NXT(a_emit_valid, clk, rst, emit_fire, result_valid)
  `CFL_ASSERT_NXT(a_emit_clear, clk, rst, emit_fire, run_min == '1)
  `CFL_ASSERT_NXT(a_div_done, clk, rst, state == S_DIV && dcnt == 7'h7f, state != S_DIV)

endmodule

`default_nettype wire

// ===== hdl/cfl_time_step_reduction.sv =====
// Latency rises from a non-material particle through a model with no wave speed
// and a fluid to an elastic solid; the last particle adds the set-end stage.
// The back end finishes one particle before it pops the next; the bit-serial
// divider and square root dominate. A two-word queue buffers input.
// Reset: synchronous; registers take their defaults and the minimum is all ones.
// ----------------------------------------------------------------------------
// CFL time step reduction
// Running minimum of per-particle stable steps, scaled and clamped at set end,
// or replaced by the fixed step in fixed mode.
`default_nettype none

module cfl_time_step_reduction import cfl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_data,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic        is_material,
  input  wire logic [1:0]  model_kind,
  input  wire logic [47:0] youngs_modulus,
  input  wire logic [14:0] poisson_ratio,
  input  wire logic [47:0] fluid_modulus,
  input  wire logic [39:0] mass_density,
  input  wire logic signed [47:0] vel_x,
  input  wire logic signed [47:0] vel_y,
  input  wire logic signed [47:0] vel_z,
  input  wire logic        last_particle,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [63:0]      time_step
);

  cfg_t  cfg;
  word_t q_wdata;
  word_t q_rdata;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  cfl_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .item_valid, .item_stall, .is_material, .model_kind, .youngs_modulus,
    .poisson_ratio, .fluid_modulus, .mass_density, .vel_x, .vel_y, .vel_z,
    .last_particle, .q_full, .q_push, .q_wdata, .cfg
  );

  cfl_queue u_queue (
    .clk, .rst, .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty)
  );

  cfl_back u_back (
    .clk, .rst, .cfg, .q_rdata, .q_empty, .q_pop,
    .result_valid, .result_stall, .time_step
  );

endmodule

`default_nettype wire
